/* hdl/assert_macros.svh */
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/gcd_pkg.sv */
// package with the shared step unit operation codes
`default_nettype none

package gcd_pkg;

  // operation of the shared step unit
  typedef enum logic {
    OP_DIV = 1'b0,
    OP_MUL = 1'b1
  } unit_op_e;

endpackage

`default_nettype wire

/* hdl/gcd_lcm_unit_top.sv */
// gcd and lcm unit: stream ports, sequencer and operand registers
//
// usage: one transaction on the slave stream carries operand_a (low half of
// tdata) and operand_b (next half). The block answers with one transaction on
// the master stream: gcd_value and lcm_low in tdata, lcm_overflow in tuser.
// s_axis_tready is high only while no item is being worked on; the sequencer
// then runs euclid's remainder loop, each remainder found by restoring
// division on the shared step unit. The lcm takes one more division (a / gcd)
// and one shift-add multiplication (quotient * b) on the same unit; these run
// only when both operands are nonzero; a zero operand_b skips every division.
// the result sits in an output register, so a new item is accepted while an
// earlier result still waits; when the receiver stalls and that register is
// full, the finished item waits in the sequencer and input stays blocked.
// reset clears the sequencer and the output valid flag; no other state.
`default_nettype none
`include "assert_macros.svh"

module gcd_lcm_unit_top
  import gcd_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic s_axis_tvalid,
  output logic       s_axis_tready,
  // operand_a, operand_b
  input  wire  logic [((2*OPERAND_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic       m_axis_tvalid,
  input  wire  logic m_axis_tready,
  // gcd_value, lcm_low
  output logic [((2*OPERAND_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // lcm_overflow
  output logic [0:0] m_axis_tuser
);

  localparam int unsigned W      = OPERAND_WIDTH;
  localparam int unsigned DATA_W = ((2*OPERAND_WIDTH+7)/8)*8;
  localparam int unsigned CNT_W  = $clog2(OPERAND_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPERAND_WIDTH - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIVG = 3'd1;
  localparam logic [2:0] ST_DIVL = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]     a_q, a_d;
  logic [W-1:0]     b_q, b_d;
  logic [W-1:0]     g_q, g_d;
  logic [W-1:0]     hi_q, hi_d;
  logic [W-1:0]     lo_q, lo_d;
  logic [W-1:0]     opd_q, opd_d;
  logic             out_valid_q, out_valid_d;
  logic [W-1:0]     gcd_out_q;
  logic [W-1:0]     lcm_out_q;
  logic             ovf_out_q;

  logic [W-1:0]     in_a;
  logic [W-1:0]     in_b;
  logic             in_fire;
  logic             out_load;
  logic             cnt_last;
  unit_op_e         unit_op;
  logic [W-1:0]     unit_hi;
  logic [W-1:0]     unit_lo;

  // input unpacking and handshakes
  assign in_a          = s_axis_tdata[W-1:0];
  assign in_b          = s_axis_tdata[2*W-1:W];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);
  assign cnt_last      = (cnt_q == CNT_LAST);
  assign unit_op       = (state_q == ST_MUL) ? OP_MUL : OP_DIV;

  // shared step unit
  gcd_step_unit #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_step (
    .op_i (unit_op),
    .hi_i (hi_q),
    .lo_i (lo_q),
    .opd_i(opd_q),
    .hi_o (unit_hi),
    .lo_o (unit_lo)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    a_d     = a_q;
    b_d     = b_q;
    g_d     = g_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    opd_d   = opd_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          a_d   = in_a;
          b_d   = in_b;
          cnt_d = '0;
          hi_d  = '0;
          if (in_b == '0) begin
            g_d     = in_a;
            lo_d    = '0;
            state_d = ST_FIN;
          end else begin
            lo_d    = in_a;
            opd_d   = in_b;
            state_d = ST_DIVG;
          end
        end
      end
      ST_DIVG: begin
        hi_d  = unit_hi;
        lo_d  = unit_lo;
        cnt_d = cnt_q + 1'b1;
        if (cnt_last) begin
          cnt_d = '0;
          hi_d  = '0;
          if (unit_hi == '0) begin
            g_d = opd_q;
            if (a_q == '0) begin
              lo_d    = '0;
              state_d = ST_FIN;
            end else begin
              lo_d    = a_q;
              state_d = ST_DIVL;
            end
          end else begin
            // next euclid step: old divisor over the remainder
            lo_d  = opd_q;
            opd_d = unit_hi;
          end
        end
      end
      ST_DIVL: begin
        hi_d  = unit_hi;
        lo_d  = unit_lo;
        cnt_d = cnt_q + 1'b1;
        if (cnt_last) begin
          // quotient a / gcd times b
          cnt_d   = '0;
          hi_d    = '0;
          opd_d   = b_q;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        hi_d  = unit_hi;
        lo_d  = unit_lo;
        cnt_d = cnt_q + 1'b1;
        if (cnt_last) begin
          cnt_d   = '0;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  // output register valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    g_q   <= g_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    opd_q <= opd_d;
    if (out_load) begin
      gcd_out_q <= g_q;
      lcm_out_q <= lo_q;
      ovf_out_q <= |hi_q;
    end
  end

  // output packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(DATA_W-2*W){1'b0}}, lcm_out_q, gcd_out_q};
  assign m_axis_tuser  = ovf_out_q;

  `ASSERT_CLK(a_div_nonzero,
    (state_q == ST_DIVG || state_q == ST_DIVL) |-> (opd_q != '0),
    "divisor is zero during a division")
  `ASSERT_CLK(a_rem_below_divisor,
    (state_q == ST_DIVG || state_q == ST_DIVL) |-> (unit_hi < opd_q),
    "partial remainder not below divisor")
  `ASSERT_CLK(a_out_from_fin,
    (!out_valid_q ##1 out_valid_q) |-> $past(state_q == ST_FIN),
    "result appeared without a finished item")
  `ASSERT_ALWAYS(a_idle_cnt_clear,
    (state_q == ST_IDLE || state_q == ST_FIN) |-> (cnt_q == '0),
    "step counter not cleared between items")

endmodule

`default_nettype wire

/* hdl/gcd_step_unit.sv */
// shared add/subtract unit doing one restoring-divide or shift-add multiply step
`default_nettype none

module gcd_step_unit
  import gcd_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  wire unit_op_e                 op_i,
  input  wire logic [OPERAND_WIDTH-1:0] hi_i,
  input  wire logic [OPERAND_WIDTH-1:0] lo_i,
  input  wire logic [OPERAND_WIDTH-1:0] opd_i,
  output logic      [OPERAND_WIDTH-1:0] hi_o,
  output logic      [OPERAND_WIDTH-1:0] lo_o
);

  localparam int unsigned W = OPERAND_WIDTH;

  logic [W:0]   trial;
  logic [W+1:0] add_x;
  logic [W+1:0] add_y;
  logic         add_cin;
  logic [W+1:0] sum;
  logic         fits;

  // partial remainder shifted left by one with the next dividend bit
  assign trial = {hi_i, lo_i[W-1]};

  // operand selection for the single adder
  always_comb begin
    if (op_i == OP_MUL) begin
      add_x   = {2'b00, hi_i};
      add_y   = lo_i[0] ? {2'b00, opd_i} : '0;
      add_cin = 1'b0;
    end else begin
      add_x   = {1'b0, trial};
      add_y   = ~{2'b00, opd_i};
      add_cin = 1'b1;
    end
  end

  assign sum  = add_x + add_y + {{(W+1){1'b0}}, add_cin};
  assign fits = ~sum[W+1];

  // next remainder/quotient or next product halves
  always_comb begin
    if (op_i == OP_MUL) begin
      hi_o = sum[W:1];
      lo_o = {sum[0], lo_i[W-1:1]};
    end else begin
      hi_o = fits ? sum[W-1:0] : trial[W-1:0];
      lo_o = {lo_i[W-2:0], fits};
    end
  end

endmodule

`default_nettype wire
